FILE: hdl/sfd_pkg.sv
package sfd_pkg;

  localparam int DATA_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int GAIN_W    = 17;
  localparam int WIDTH_W   = 18;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic [DELAY_W-1:0] DELAY_LEFT_RST  = 16'd11025;
  localparam logic [DELAY_W-1:0] DELAY_RIGHT_RST = 16'd11025;
  localparam logic [GAIN_W-1:0]  FEEDBACK_RST    = 17'd22937;
  localparam logic [GAIN_W-1:0]  WET_MIX_RST     = 17'd22937;
  localparam logic [WIDTH_W-1:0] STEREO_W_RST    = 18'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LEFT    = 3'd0,
    REG_DELAY_RIGHT   = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_WET_MIX       = 3'd3,
    REG_STEREO_WIDTH  = 3'd4
  } reg_idx_e;

  // one state per multiplier issue slot in the arithmetic phase
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_LATCH,
    ST_FB_L,
    ST_FB_R,
    ST_MID,
    ST_SIDE0,
    ST_DRY_L,
    ST_SIDE,
    ST_DRY_R,
    ST_WET_L,
    ST_WET_R,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_left;
    logic signed [DATA_W-1:0] sample_right;
    logic                     last_frame;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_left;
    logic signed [DATA_W-1:0] out_right;
    logic                     last_frame_out;
  } out_rsp_t;

endpackage

FILE: hdl/stereo_feedback_delay_top.sv
// Stereo feedback delay on Q16.16 frames. After reset the two delay lines are
// swept to zero, one entry per cycle, so the block accepts no frame until the
// sweep is done; configuration writes are taken throughout. A frame's result
// is built from nine products run one after another through a single
// registered 32x32 multiplier, plus the delay-line address, read and write
// steps; one frame is in work at a time. A finished result waits in the output
// register while the next frame is taken in. Registers should be written only
// while no frame is in work.
module stereo_feedback_delay_top import sfd_pkg::*; #(
  parameter int DELAY_DEPTH = 65536,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_rsp_t             out_rsp_o
);

  localparam int AW = $clog2(DELAY_DEPTH);
  // delay reduction: enough conditional subtracts of DEPTH<<k to bring a
  // 16-bit delay below the depth
  localparam int MOD_STEPS = (DELAY_DEPTH >= (2 ** DELAY_W)) ? 0 :
      $clog2(((2 ** DELAY_W) + DELAY_DEPTH - 1) / DELAY_DEPTH);
  localparam int RW = DELAY_W + 7;
  localparam logic [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] HALF = DATA_W'(1) << (FRAC_BITS - 1);

  state_e state_q, state_d;

  logic [DELAY_W-1:0] delay_left_q, delay_right_q;
  logic [GAIN_W-1:0]  feedback_q, wet_mix_q;
  logic [WIDTH_W-1:0] stereo_width_q;

  logic [AW-1:0] widx_q, clr_q;
  logic [AW-1:0] rd_addr_l_q, rd_addr_r_q;

  in_req_t            req_q;
  logic [DATA_W-1:0]  dl_q, dr_q, fbl_q, fbr_q, mid_q, side_q, acc_l_q, acc_r_q;
  logic               out_valid_q;
  out_rsp_t           out_rsp_q;

  logic [DATA_W-1:0]  mul_a, mul_b, mul_res;
  logic [DATA_W-1:0]  rdata_l, rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DATA_W-1:0]  wdata_l, wdata_r;
  logic [DATA_W-1:0]  dry;
  logic               out_free;

  function automatic logic [AW-1:0] rd_pos(input logic [DELAY_W-1:0] delay,
                                           input logic [AW-1:0]      widx);
    logic [RW-1:0] r;
    logic [AW:0]   s;
    r = RW'(delay);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (RW'(DELAY_DEPTH) << k)) begin
        r = r - (RW'(DELAY_DEPTH) << k);
      end
    end
    s = {1'b0, widx} + (AW+1)'(DELAY_DEPTH) - (AW+1)'(r);
    if (s >= (AW+1)'(DELAY_DEPTH)) begin
      s = s - (AW+1)'(DELAY_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_left_q   <= DELAY_LEFT_RST;
      delay_right_q  <= DELAY_RIGHT_RST;
      feedback_q     <= FEEDBACK_RST;
      wet_mix_q      <= WET_MIX_RST;
      stereo_width_q <= STEREO_W_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELAY_LEFT:    delay_left_q   <= cfg_data_i[DELAY_W-1:0];
        REG_DELAY_RIGHT:   delay_right_q  <= cfg_data_i[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: feedback_q     <= cfg_data_i[GAIN_W-1:0];
        REG_WET_MIX:       wet_mix_q      <= cfg_data_i[GAIN_W-1:0];
        REG_STEREO_WIDTH:  stereo_width_q <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign dry      = ONE - DATA_W'(wet_mix_q);
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = widx_q;
    wdata_l   = req_q.sample_left + fbl_q;
    wdata_r   = req_q.sample_right + fbr_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        wdata_l   = '0;
        wdata_r   = '0;
        if (clr_q == AW'(DELAY_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE:  if (in_valid_i) state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_READ;
      ST_READ:  state_d = ST_LATCH;
      ST_LATCH: state_d = ST_FB_L;
      ST_FB_L: begin
        mul_a   = dl_q;
        mul_b   = DATA_W'(feedback_q);
        state_d = ST_FB_R;
      end
      ST_FB_R: begin
        mul_a   = dr_q;
        mul_b   = DATA_W'(feedback_q);
        state_d = ST_MID;
      end
      ST_MID: begin
        mul_a   = dl_q + dr_q;
        mul_b   = HALF;
        state_d = ST_SIDE0;
      end
      ST_SIDE0: begin
        mul_a   = dl_q - dr_q;
        mul_b   = HALF;
        mem_we  = 1'b1;
        state_d = ST_DRY_L;
      end
      ST_DRY_L: begin
        mul_a   = req_q.sample_left;
        mul_b   = dry;
        state_d = ST_SIDE;
      end
      ST_SIDE: begin
        mul_a   = side_q;
        mul_b   = DATA_W'(stereo_width_q);
        state_d = ST_DRY_R;
      end
      ST_DRY_R: begin
        mul_a   = req_q.sample_right;
        mul_b   = dry;
        state_d = ST_WET_L;
      end
      ST_WET_L: begin
        mul_a   = mid_q + side_q;
        mul_b   = DATA_W'(wet_mix_q);
        state_d = ST_WET_R;
      end
      ST_WET_R: begin
        mul_a   = mid_q - side_q;
        mul_b   = DATA_W'(wet_mix_q);
        state_d = ST_SUM;
      end
      ST_SUM:   state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // control counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        widx_q      <= (widx_q == AW'(DELAY_DEPTH - 1)) ? '0 : widx_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath; each product capture takes the product issued the cycle before
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_req_i;
    unique case (state_q)
      ST_ADDR: begin
        rd_addr_l_q <= rd_pos(delay_left_q, widx_q);
        rd_addr_r_q <= rd_pos(delay_right_q, widx_q);
      end
      ST_LATCH: begin
        dl_q <= rdata_l;
        dr_q <= rdata_r;
      end
      ST_FB_R:  fbl_q   <= mul_res;
      ST_MID:   fbr_q   <= mul_res;
      ST_SIDE0: mid_q   <= mul_res;
      ST_DRY_L: side_q  <= mul_res;
      ST_SIDE:  acc_l_q <= mul_res;
      ST_DRY_R: side_q  <= mul_res;
      ST_WET_L: acc_r_q <= mul_res;
      ST_WET_R: acc_l_q <= acc_l_q + mul_res;
      ST_SUM:   acc_r_q <= acc_r_q + mul_res;
      ST_DONE: begin
        if (out_free) begin
          out_rsp_q.out_left       <= acc_l_q;
          out_rsp_q.out_right      <= acc_r_q;
          out_rsp_q.last_frame_out <= req_q.last_frame;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  sfd_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  sfd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DELAY_DEPTH)
  ) u_line_left (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata_l),
    .raddr_i (rd_addr_l_q),
    .rdata_o (rdata_l)
  );

  sfd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DELAY_DEPTH)
  ) u_line_right (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata_r),
    .raddr_i (rd_addr_r_q),
    .rdata_o (rdata_r)
  );

endmodule

FILE: hdl/sfd_ram.sv
module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sfd_mul.sv
module sfd_mul import sfd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic [DATA_W-1:0]        res_o
);

  logic signed [2*DATA_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // floor shift of the full product, low word kept
  assign res_o = prod_q[FRAC_BITS+DATA_W-1:FRAC_BITS];

endmodule
